### rtl/core/sll_pkg.sv
`default_nettype none

package sll_pkg;

  // fixed widths of the item fields and the register
  localparam int NODE_W      = 16;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int SLOT_IDX_W  = 4;
  localparam int ACT_W       = 5;

  // list geometry
  localparam int SLOTS_DEFAULT = 16;
  localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_ACTIVE_SLOTS = 1'b0;

  typedef enum logic [FUNC_W-1:0] {
    F_INSERT = 2'd0,
    F_REMOVE = 2'd1,
    F_CHECK  = 2'd2,
    F_NOP    = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  // result of one operation, engine to output stage
  typedef struct packed {
    status_e               status;
    logic                  found;
    logic [SLOT_IDX_W-1:0] slot_index;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/sll_engine.sv
`default_nettype none

module sll_engine #(
  parameter int SLOTS = sll_pkg::SLOTS_DEFAULT
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [sll_pkg::ACT_W-1:0]  active_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [sll_pkg::FUNC_W-1:0] func_i,
  input  wire logic [sll_pkg::NODE_W-1:0] node_id_i,
  output logic                            res_valid_o,
  input  wire logic                       res_ready_i,
  output sll_pkg::res_t                   res_o
);
  import sll_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = (CW > ACT_W) ? CW : ACT_W;

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] node;
  } slot_t;

  typedef enum logic [4:0] {
    S_CLR   = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  slot_t mem [SLOTS];
  slot_t rdata_q;
  logic [IW-1:0] raddr, waddr;
  slot_t wdata;
  logic we;

  func_e func_q, func_d;
  logic [NODE_W-1:0] id_q, id_d;
  logic [CW-1:0] n_q, n_d, ridx_q, ridx_d;
  logic [IW-1:0] pidx_q, pidx_d, where_q, where_d, clr_q, clr_d;
  logic pend_q, pend_d, found_q, found_d;
  status_e status_q, status_d;

  logic [EW-1:0] act_ext;
  logic [CW-1:0] n_start, n_m1;
  logic issue, hit, last;

  assign act_ext = EW'(active_i);
  assign n_start = (act_ext > EW'(SLOTS)) ? CW'(SLOTS) : CW'(active_i);
  assign n_m1    = n_q - CW'(1);
  assign issue   = ridx_q < n_q;
  assign hit     = rdata_q.valid && (rdata_q.node == id_q);
  assign last    = CW'(pidx_q) == n_m1;

  always_comb begin
    state_d  = state_q;
    func_d   = func_q;
    id_d     = id_q;
    n_d      = n_q;
    ridx_d   = ridx_q;
    pidx_d   = pidx_q;
    pend_d   = pend_q;
    found_d  = found_q;
    where_d  = where_q;
    status_d = status_q;
    clr_d    = clr_q;
    raddr    = ridx_q[IW-1:0];
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + IW'(1);
        if (clr_q == IW'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          func_d   = func_e'(func_i);
          id_d     = node_id_i;
          n_d      = n_start;
          ridx_d   = '0;
          pend_d   = 1'b0;
          found_d  = 1'b0;
          where_d  = '0;
          status_d = ST_DONE;
          if (func_e'(func_i) == F_NOP) begin
            state_d = S_DONE;
          end else if (n_start == '0) begin
            // no active slot: nothing to scan
            if (func_e'(func_i) == F_INSERT) begin
              status_d = ST_FULL;
            end else if (func_e'(func_i) == F_REMOVE) begin
              status_d = ST_NOTFOUND;
            end
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        pend_d = issue;
        pidx_d = ridx_q[IW-1:0];
        if (issue) begin
          ridx_d = ridx_q + CW'(1);
        end
        if (pend_q) begin
          case (func_q)
            F_INSERT: begin
              if (!rdata_q.valid) begin
                we         = 1'b1;
                waddr      = pidx_q;
                wdata.valid = 1'b1;
                wdata.node = id_q;
                found_d    = 1'b1;
                where_d    = pidx_q;
                pend_d     = 1'b0;
                state_d    = S_DONE;
              end else begin
                if (hit && !found_q) begin
                  found_d = 1'b1;
                  where_d = pidx_q;
                end
                if (last) begin
                  status_d = ST_FULL;
                  pend_d   = 1'b0;
                  state_d  = S_DONE;
                end
              end
            end
            F_REMOVE: begin
              if (hit) begin
                found_d = 1'b1;
                where_d = pidx_q;
                ridx_d  = CW'(pidx_q) + CW'(1);
                pend_d  = 1'b0;
                state_d = S_SHIFT;
              end else if (last) begin
                status_d = ST_NOTFOUND;
                pend_d   = 1'b0;
                state_d  = S_DONE;
              end
            end
            default: begin
              if (hit) begin
                found_d = 1'b1;
                where_d = pidx_q;
                pend_d  = 1'b0;
                state_d = S_DONE;
              end else if (last) begin
                pend_d  = 1'b0;
                state_d = S_DONE;
              end
            end
          endcase
        end
      end

      S_SHIFT: begin
        // read slot i+2 while slot i takes the entry of slot i+1 read in the previous cycle
        pend_d = issue;
        pidx_d = ridx_q[IW-1:0];
        if (issue) begin
          ridx_d = ridx_q + CW'(1);
        end
        if (pend_q) begin
          we    = 1'b1;
          waddr = pidx_q - IW'(1);
          wdata = rdata_q;
        end else if (!issue) begin
          we      = 1'b1;
          waddr   = n_m1[IW-1:0];
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    id_q     <= id_d;
    n_q      <= n_d;
    ridx_q   <= ridx_d;
    pidx_q   <= pidx_d;
    found_q  <= found_d;
    where_q  <= where_d;
    status_q <= status_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
  end

  assign res_o.status     = status_q;
  assign res_o.found      = found_q;
  assign res_o.slot_index = SLOT_IDX_W'(where_q);

endmodule

`default_nettype wire

### rtl/core/slot_list_insert_remove_lookup.sv
`default_nettype none

// compacting slot list: a table of SLOTS node ids with a valid mark each, kept in
// one synchronous memory. insert fills the lowest empty active slot (or reports
// full), remove takes out the lowest match and slides the later active slots down
// by one, check reports the lowest match. one item is worked on at a time: the
// scan reads one slot per cycle through the single memory read port, at most up to
// the last of the n active slots (n capped at SLOTS). an item passes through the
// accept cycle, the scan and the hand-over of its result; a remove that matches
// at slot k then shifts the later active slots down by one, one copy per cycle.
// after reset the memory is cleared slot by slot, and no item is taken during
// that pass; register writes are taken at any time. a finished result sits in an
// output register, so the next item is accepted while it waits; a result that
// finds that register full and stalled holds the engine until it can move over.
module slot_list_insert_remove_lookup #(
  parameter int SLOTS = sll_pkg::SLOTS_DEFAULT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // apb register port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sll_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [sll_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [sll_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  // operation beats
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [sll_pkg::FUNC_W-1:0]     func_i,
  input  wire logic [sll_pkg::NODE_W-1:0]     node_id_i,
  // result beats
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [sll_pkg::STATUS_W-1:0]        status_o,
  output logic                                found_o,
  output logic [sll_pkg::SLOT_IDX_W-1:0]      slot_index_o
);
  import sll_pkg::*;

  // active slot count register
  logic [ACT_W-1:0] active_q;
  logic             reg_sel;
  logic             cfg_wr;

  assign reg_sel = paddr[APB_ADDR_W-1:2] == REG_ACTIVE_SLOTS;
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? APB_DATA_W'(active_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACT_RESET;
    end else if (cfg_wr) begin
      active_q <= pwdata[ACT_W-1:0];
    end
  end

  // engine: scan, insert and compacting shift over the slot memory
  logic res_valid, res_ready;
  res_t res;

  sll_engine #(
    .SLOTS(SLOTS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .active_i   (active_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .node_id_i  (node_id_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // output register, frees the engine as soon as its result is taken over
  logic out_valid_q;
  res_t out_q;

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign found_o      = out_q.found;
  assign slot_index_o = out_q.slot_index;

endmodule

`default_nettype wire

### rtl/core/sll_checker.sv
`default_nettype none

module sll_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           psel,
  input wire logic                           penable,
  input wire logic                           pwrite,
  input wire logic [sll_pkg::APB_ADDR_W-1:0] paddr,
  input wire logic [sll_pkg::APB_DATA_W-1:0] pwdata,
  input wire logic [sll_pkg::APB_DATA_W-1:0] prdata,
  input wire logic                           pready,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic [sll_pkg::FUNC_W-1:0]     func_i,
  input wire logic [sll_pkg::NODE_W-1:0]     node_id_i,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [sll_pkg::STATUS_W-1:0]   status_o,
  input wire logic                           found_o,
  input wire logic [sll_pkg::SLOT_IDX_W-1:0] slot_index_o
);
  import sll_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(found_o) && $stable(slot_index_o))
    else $error("result beat changed while stalled");

  // one item at a time: the engine is busy right after it takes a beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while the previous one is still in work");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_DONE) || (status_o == ST_FULL) ||
    (status_o == ST_NOTFOUND))
    else $error("unknown status code");

  // a failed remove reports no match and no slot
  a_notfound_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_NOTFOUND) |-> !found_o && (slot_index_o == '0))
    else $error("not found result carries a slot");

  // a miss without error reports slot zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_DONE) && !found_o |-> slot_index_o == '0)
    else $error("miss reports a nonzero slot");

endmodule

bind slot_list_insert_remove_lookup sll_checker u_sll_checker (.*);

`default_nettype wire
